// ===== rtl/lrut_pkg.sv =====
// ============================================================================
// lrut_pkg: shared types and constants of the LRU entry tracker
// Result record, field widths and configuration register map.
// ============================================================================
package lrut_pkg;

   // Widths fixed by the item format
   localparam int IDX_FIELD_W = 5;
   localparam int IN_SPAN     = 1 << IDX_FIELD_W;
   localparam int LIMIT_W     = 6;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index as decoded from the word address
   localparam logic REG_KEEP_LIMIT = 1'b0;

   localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET = 6'd32;

   typedef logic [IDX_FIELD_W-1:0] idx_field_type;

   typedef struct packed {
      logic          hit;
      logic          evict_valid;
      idx_field_type evicted_index;
      logic          last;
   } rsp_type;

endpackage

// ===== rtl/lrut_out.sv =====
// ============================================================================
// lrut_out: result output register
// Holds one result until the consumer takes it; frees in the cycle it drains.
// ============================================================================
module lrut_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lrut_pkg::rsp_type push_data,
   output logic              push_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic              rsp_evict_valid,
   output logic [4:0]        rsp_evicted_index,
   output logic              rsp_last
);

   logic              valid_ff;
   logic              valid_in;
   lrut_pkg::rsp_type data_ff;

   assign push_free = !valid_ff || !rsp_stall;
   assign valid_in  = (push_valid && push_free) || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load only when the slot is empty or drains this cycle
   always_ff @(posedge clock) begin
      if (push_valid && push_free) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_hit           = data_ff.hit;
   assign rsp_evict_valid   = data_ff.evict_valid;
   assign rsp_evicted_index = data_ff.evicted_index;
   assign rsp_last          = data_ff.last;

endmodule

// ===== rtl/lru_entry_tracker.sv =====
// ============================================================================
// lru_entry_tracker: least-recently-used order over indexed cache entries
// Doubly linked recency list in two link memories, walked by a sequencer.
// ============================================================================
// Each request names an entry (index reduced modulo ENTRIES). A resident entry
// is a hit and moves to the most-recent end; otherwise the entry is loaded at
// the most-recent end and the oldest entries are evicted until the resident
// count is at most keep_limit. Results: one hit/miss report, then one transfer
// per evicted entry, oldest first, with last on the final one. Sequence: a hit
// on the most-recent entry passes LOOKUP and REPORT, any other hit also PROMO
// (the link memories have one write port each, so the relink is split over
// LOOKUP and PROMO), a miss LOOKUP, REPORT and one EVICT per eviction; result
// stalls hold REPORT and EVICT. One request is in work at a time. After reset
// the resident-mark memory is cleared in S_CLEAR, while no request is taken;
// keep_limit can be written at any time through the register port (offset 0).
module lru_entry_tracker #(
   parameter int ENTRIES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [4:0]                        req_entry_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_evict_valid,
   output logic [4:0]                        rsp_evicted_index,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lrut_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lrut_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lrut_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lrut_pkg::LIMIT_W) ? CNT_W : lrut_pkg::LIMIT_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [CMP_W-1:0] cmp_type;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_LOOKUP = 6'b000100,
      S_PROMO  = 6'b001000,
      S_REPORT = 6'b010000,
      S_EVICT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   idx_type   e_ff, e_in;
   idx_type   newest_ff, newest_in;
   idx_type   oldest_ff, oldest_in;
   idx_type   clr_ff, clr_in;
   cnt_type   count_ff, count_in;
   logic      hit_ff, hit_in;
   logic [lrut_pkg::LIMIT_W-1:0] keep_limit_ff;

   // resident marks and recency links
   logic    res_mem [ENTRIES];
   idx_type nn_mem  [ENTRIES];
   idx_type no_mem  [ENTRIES];

   logic    res_rd_ff;
   idx_type nn_rd_ff, no_rd_ff;
   idx_type res_raddr, nn_raddr, no_raddr;
   logic    res_we, nn_we, no_we;
   idx_type res_waddr, nn_waddr, no_waddr;
   logic    res_wdata;
   idx_type nn_wdata, no_wdata;

   idx_type mod_tbl [lrut_pkg::IN_SPAN];
   idx_type req_idx;

   logic              out_push, out_free;
   lrut_pkg::rsp_type out_data;

   cnt_type count_inc, count_dec;
   cmp_type limit_ext, count_ext, dec_ext;
   logic    over_limit, dec_over, evict_go;
   logic    csr_write;

   // ------------------------------------------------------------------------
   // Index reduction table
   // ------------------------------------------------------------------------
   for (genvar gi = 0; gi < lrut_pkg::IN_SPAN; gi++) begin : g_mod
      assign mod_tbl[gi] = idx_type'(gi % ENTRIES);
   end

   assign req_idx = mod_tbl[req_entry_index];

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_limit_ff <= lrut_pkg::KEEP_LIMIT_RESET;
      end else if (csr_write && (csr_paddr[2] == lrut_pkg::REG_KEEP_LIMIT)) begin
         keep_limit_ff <= csr_pwdata[lrut_pkg::LIMIT_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == lrut_pkg::REG_KEEP_LIMIT) begin
         csr_prdata = lrut_pkg::CSR_DATA_W'(keep_limit_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_rd_ff <= res_mem[res_raddr];
   end

   always_ff @(posedge clock) begin
      if (nn_we) begin
         nn_mem[nn_waddr] <= nn_wdata;
      end
      nn_rd_ff <= nn_mem[nn_raddr];
   end

   always_ff @(posedge clock) begin
      if (no_we) begin
         no_mem[no_waddr] <= no_wdata;
      end
      no_rd_ff <= no_mem[no_raddr];
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);

   assign count_inc  = count_ff + cnt_type'(1);
   assign count_dec  = count_ff - cnt_type'(1);
   assign limit_ext  = cmp_type'(keep_limit_ff);
   assign count_ext  = cmp_type'(count_ff);
   assign dec_ext    = cmp_type'(count_dec);
   assign over_limit = count_ext > limit_ext;
   assign dec_over   = dec_ext > limit_ext;
   assign evict_go   = !hit_ff && over_limit;

   always_comb begin
      state_in  = state_ff;
      e_in      = e_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      hit_in    = hit_ff;
      res_raddr = req_idx;
      nn_raddr  = req_idx;
      no_raddr  = req_idx;
      res_we    = 1'b0;
      res_waddr = e_ff;
      res_wdata = 1'b0;
      nn_we     = 1'b0;
      nn_waddr  = e_ff;
      nn_wdata  = e_ff;
      no_we     = 1'b0;
      no_waddr  = e_ff;
      no_wdata  = newest_ff;
      out_push  = 1'b0;
      out_data  = '0;

      case (state_ff)
         S_CLEAR: begin
            res_we    = 1'b1;
            res_waddr = clr_ff;
            res_wdata = 1'b0;
            clr_in    = clr_ff + idx_type'(1);
            if (clr_ff == idx_type'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // reads of the named entry are issued at the transfer
            if (req_valid) begin
               e_in     = req_idx;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            hit_in = res_rd_ff;
            if (res_rd_ff) begin
               if (e_ff == newest_ff) begin
                  state_in = S_REPORT;
               end else begin
                  // unlink: bypass the entry between its neighbors
                  if (e_ff == oldest_ff) begin
                     oldest_in = nn_rd_ff;
                  end else begin
                     nn_we    = 1'b1;
                     nn_waddr = no_rd_ff;
                     nn_wdata = nn_rd_ff;
                  end
                  no_we    = 1'b1;
                  no_waddr = nn_rd_ff;
                  no_wdata = no_rd_ff;
                  state_in = S_PROMO;
               end
            end else begin
               res_we    = 1'b1;
               res_waddr = e_ff;
               res_wdata = 1'b1;
               count_in  = count_inc;
               newest_in = e_ff;
               if (count_ff == '0) begin
                  oldest_in = e_ff;
               end else begin
                  no_we    = 1'b1;
                  no_waddr = e_ff;
                  no_wdata = newest_ff;
                  nn_we    = 1'b1;
                  nn_waddr = newest_ff;
                  nn_wdata = e_ff;
               end
               state_in = S_REPORT;
            end
         end
         S_PROMO: begin
            no_we     = 1'b1;
            no_waddr  = e_ff;
            no_wdata  = newest_ff;
            nn_we     = 1'b1;
            nn_waddr  = newest_ff;
            nn_wdata  = e_ff;
            newest_in = e_ff;
            state_in  = S_REPORT;
         end
         S_REPORT: begin
            // prefetch the link after the oldest entry for the first eviction
            nn_raddr = oldest_ff;
            if (out_free) begin
               out_push      = 1'b1;
               out_data.hit  = hit_ff;
               out_data.last = !evict_go;
               state_in      = evict_go ? S_EVICT : S_IDLE;
            end
         end
         S_EVICT: begin
            nn_raddr = oldest_ff;
            if (out_free) begin
               out_push               = 1'b1;
               out_data.evict_valid   = 1'b1;
               out_data.evicted_index = lrut_pkg::idx_field_type'(oldest_ff);
               out_data.last          = !dec_over;
               res_we                 = 1'b1;
               res_waddr              = oldest_ff;
               res_wdata              = 1'b0;
               count_in               = count_dec;
               if (count_dec != '0) begin
                  oldest_in = nn_rd_ff;
                  nn_raddr  = nn_rd_ff;
               end
               if (!dec_over) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff   <= e_in;
      hit_ff <= hit_in;
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   lrut_out u_out (
      .clock             (clock),
      .reset             (reset),
      .push_valid        (out_push),
      .push_data         (out_data),
      .push_free         (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evict_valid   (rsp_evict_valid),
      .rsp_evicted_index (rsp_evicted_index),
      .rsp_last          (rsp_last)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(ENTRIES))
      else $error("resident count above entry count");

   a_single_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && (count_ff == cnt_type'(1)) |-> (newest_ff == oldest_ff))
      else $error("one resident entry but list ends differ");

   a_evict_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVICT) && out_push && out_data.last |=> !over_limit)
      else $error("eviction ended above the keep limit");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPORT) && out_push && hit_ff |=> (state_ff == S_IDLE))
      else $error("hit report followed by evictions");

endmodule

// ===== tb/sv/tb_lru_entry_tracker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_lru_entry_tracker: self-checking testbench for the LRU entry tracker
// Offers entry accesses with random gaps and result stalls and keeps its own
// recency list to predict each hit/miss report and the eviction transfers
// that follow it. Every result transfer is checked in order. keep_limit is
// reprogrammed between phases and read back after most writes.
// ============================================================================
module tb_lru_entry_tracker;

   localparam int ENTRIES     = 32;
   localparam int CLK_HALF    = 5;
   localparam int HOLD_CYCLES = 200;
   localparam logic CSR_IDX_SPARE = 1'b1;   // first index past the register map

   typedef logic [lrut_pkg::LIMIT_W-1:0] limit_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lrut_pkg::idx_field_type         req_entry_index = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_hit;
   logic                            rsp_evict_valid;
   logic [4:0]                      rsp_evicted_index;
   logic                            rsp_last;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [lrut_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [lrut_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [lrut_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   lru_entry_tracker #(.ENTRIES(ENTRIES)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evict_valid   (rsp_evict_valid),
      .rsp_evicted_index (rsp_evicted_index),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Stimulus and expectation stores
   lrut_pkg::idx_field_type access_q[$];
   lrut_pkg::rsp_type       due_reports[$];

   // Recency list kept alongside the block
   logic                    present    [ENTRIES] = '{default: 1'b0};
   lrut_pkg::idx_field_type link_newer [ENTRIES] = '{default: '0};
   lrut_pkg::idx_field_type link_older [ENTRIES] = '{default: '0};
   lrut_pkg::idx_field_type mru = '0;
   lrut_pkg::idx_field_type lru = '0;
   int unsigned             held = 0;
   limit_type               limit_model = lrut_pkg::KEEP_LIMIT_RESET;

   // Traffic shaping
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   logic        calm = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_on = 1'b0;
   logic        req_taken = 1'b0;

   int unsigned errors = 0;
   int unsigned hits = 0;
   int unsigned misses = 0;
   int unsigned evictions = 0;
   int unsigned settings = 0;
   int unsigned results_seen = 0;
   int unsigned held_off_cycles = 0;

   initial begin : clock_gen
      forever #CLK_HALF clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("MISMATCH at %0t: %s got %0d want %0d (result %0d)",
               $realtime, what, got, want, results_seen);
      errors++;
   endtask

   function automatic void queue_access(input lrut_pkg::idx_field_type e);
      access_q = {access_q, e};
   endfunction

   function automatic void add_report(input lrut_pkg::rsp_type r);
      due_reports = {due_reports, r};
   endfunction

   // Expected reports for one accepted access; updates the recency list.
   function automatic void track_access(input lrut_pkg::idx_field_type e);
      lrut_pkg::idx_field_type o, n, v;
      lrut_pkg::idx_field_type victims[$];
      if (present[e]) begin
         hits++;
         if (e != mru) begin
            o = link_older[e];
            n = link_newer[e];
            if (e == lru) lru = n;
            else link_newer[o] = n;
            link_older[n] = o;
            link_older[e] = mru;
            link_newer[mru] = e;
            mru = e;
         end
         add_report('{hit: 1'b1, evict_valid: 1'b0, evicted_index: '0, last: 1'b1});
         return;
      end
      misses++;
      if (held == 0) begin
         mru = e;
         lru = e;
      end else begin
         link_older[e] = mru;
         link_newer[mru] = e;
         mru = e;
      end
      present[e] = 1'b1;
      held++;
      // evict from the old end until the count fits the limit
      while (held > limit_model && held > 0) begin
         v = lru;
         present[v] = 1'b0;
         held--;
         if (held > 0) lru = link_newer[v];
         victims = {victims, v};
      end
      evictions += victims.size();
      add_report('{hit: 1'b0, evict_valid: 1'b0, evicted_index: '0,
                   last: victims.size() == 0});
      foreach (victims[k])
         add_report('{hit: 1'b0, evict_valid: 1'b1, evicted_index: victims[k],
                      last: k == victims.size() - 1});
   endfunction

   // Sample both channels at the rising edge
   always @(posedge clock) begin : observe
      lrut_pkg::rsp_type got;
      lrut_pkg::rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && hold_on && req_valid && req_stall) held_off_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_hit, rsp_evict_valid, rsp_evicted_index, rsp_last};
         if (due_reports.size() == 0) begin
            flag_mismatch("unexpected transfer, evicted_index", got.evicted_index, 0);
         end else begin
            want = due_reports.pop_front();
            if (got.hit !== want.hit) flag_mismatch("hit", got.hit, want.hit);
            if (got.evict_valid !== want.evict_valid)
               flag_mismatch("evict_valid", got.evict_valid, want.evict_valid);
            if (got.evicted_index !== want.evicted_index)
               flag_mismatch("evicted_index", got.evicted_index, want.evicted_index);
            if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
         end
         results_seen++;
      end
      if (!reset && req_valid && !req_stall) track_access(req_entry_index);
   end

   // Access driver: advance on a transfer, hold while stalled
   always @(negedge clock) begin : drive_access
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (!calm && access_q.size() != 0 && $urandom_range(99) < gap_pct) begin
            gap_left <= $urandom_range(18);
            req_valid <= 1'b0;
         end else if (access_q.size() != 0) begin
            req_valid <= 1'b1;
            req_entry_index <= access_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall bursts plus the long hold-off
   always @(negedge clock) begin : drive_stall
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
         stall_left <= $urandom_range(18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= hold_on;
      end
   end

   initial begin : rsp_hold
      wait (hold_go);
      @(negedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_on <= 1'b0;
   end

   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      logic [31:0] ignored;
      csr_access(1'b1, idx, data, ignored);
      if (idx == lrut_pkg::REG_KEEP_LIMIT) begin
         limit_model = data[lrut_pkg::LIMIT_W-1:0];
         settings++;
      end
   endtask

   task automatic check_limit();
      logic [31:0] rd;
      csr_access(1'b0, lrut_pkg::REG_KEEP_LIMIT, '0, rd);
      if (rd !== 32'(limit_model)) flag_mismatch("keep_limit readback", rd, limit_model);
   endtask

   // Block is idle once nothing is queued, offered or outstanding
   task automatic wait_idle();
      do @(negedge clock);
      while (access_q.size() != 0 || req_valid || due_reports.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Mostly a sliding working set a little larger than the limit, some noise
   task automatic offer_random(input int unsigned count, input limit_type lim);
      int unsigned             span;
      lrut_pkg::idx_field_type base;
      span = lim + 2;
      if (span > ENTRIES) span = ENTRIES;
      base = lrut_pkg::idx_field_type'($urandom());
      repeat (count) begin
         if ($urandom_range(9) == 0) base = lrut_pkg::idx_field_type'($urandom());
         if ($urandom_range(3) == 0) queue_access(lrut_pkg::idx_field_type'($urandom()));
         else queue_access(base + lrut_pkg::idx_field_type'($urandom_range(span - 1)));
      end
   endtask

   initial begin : stimulus
      lrut_pkg::idx_field_type warm_seq[10] = '{5'd0, 5'd31, 5'd0, 5'd31, 5'd5,
                                                5'd10, 5'd0, 5'd5, 5'd17, 5'd5};
      limit_type phase_limit[10] = '{6'd32, 6'd31, 6'd17, 6'd8, 6'd2,
                                     6'd63, 6'd1, 6'd0, 6'd5, 6'd12};
      int unsigned idle_mix[4] = '{0, 3, 8, 20};
      limit_type lim;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      check_limit();

      // Hits on newest, oldest and middle entries, and a miss that evicts
      write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'd4);
      @(posedge clock);
      foreach (warm_seq[i]) queue_access(warm_seq[i]);
      wait_idle();

      // Limit lowered under the resident count: next miss evicts down to it
      write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'd1);
      @(posedge clock);
      queue_access(5'd20);
      queue_access(5'd20);
      wait_idle();

      // Zero limit drops everything, the loaded entry too
      write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'hFFFF_FFC0);
      @(posedge clock);
      queue_access(5'd7);
      queue_access(5'd7);
      queue_access(5'd3);
      wait_idle();

      // Limit above the entry count; a write past the map must not land
      write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'd63);
      write_reg(CSR_IDX_SPARE, $urandom());
      check_limit();
      @(posedge clock);
      queue_access(5'd9);
      queue_access(5'd9);
      queue_access(5'd30);
      wait_idle();

      for (int p = 0; p < 12; p++) begin
         lim = (p < 10) ? phase_limit[p] : limit_type'($urandom_range(63));
         if ($urandom_range(1) == 0) write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'(lim));
         else write_reg(lrut_pkg::REG_KEEP_LIMIT, ($urandom() & 32'hFFFF_FFC0) | 32'(lim));
         check_limit();
         @(posedge clock);
         gap_pct = idle_mix[$urandom_range(3)];
         stall_pct = idle_mix[$urandom_range(3)];
         offer_random(20, lim);
         wait_idle();
      end

      // Long result hold-off while accesses keep coming
      write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'd3);
      @(posedge clock);
      gap_pct = 0;
      stall_pct = 0;
      offer_random(30, 6'd3);
      hold_go = 1'b1;
      wait_idle();

      // Closing stretch at full rate on both sides
      lim = limit_type'($urandom_range(33));
      write_reg(lrut_pkg::REG_KEEP_LIMIT, 32'(lim));
      @(posedge clock);
      calm = 1'b1;
      offer_random(20, lim);
      wait_idle();
      repeat (40) @(negedge clock);

      $display("Covered %0d accesses (%0d hits, %0d misses) and %0d evictions over %0d limits.",
               hits + misses, hits, misses, evictions, settings);
      $display("Checked %0d result transfers; input held off %0d cycles under back-pressure.",
               results_seen, held_off_cycles);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d results outstanding", due_reports.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== lru_entry_tracker.f =====
rtl/lrut_pkg.sv
rtl/lrut_out.sv
rtl/lru_entry_tracker.sv
tb/sv/tb_lru_entry_tracker.sv
